// ----- src/izh_pkg.sv -----
// Shared types, widths, register codes and saturation helper for the Izhikevich step core.
`default_nettype none
package izh_pkg;

  localparam int DATA_W        = 32;
  localparam int A_W           = 22;
  localparam int B_W           = 22;
  localparam int C_W           = 25;
  localparam int D_W           = 25;
  localparam int DT_W          = 21;
  localparam int CFG_W         = 25;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MUL_W         = 33;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int SAT_W         = 72;

  localparam logic signed [A_W-1:0]  RESET_A  = A_W'(1311);
  localparam logic signed [B_W-1:0]  RESET_B  = B_W'(13107);
  localparam logic signed [C_W-1:0]  RESET_C  = C_W'(-4259840);
  localparam logic signed [D_W-1:0]  RESET_D  = D_W'(524288);
  localparam logic        [DT_W-1:0] RESET_DT = DT_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_A    = 3'd0,
    REG_GAIN_B    = 3'd1,
    REG_RESET_C   = 3'd2,
    REG_JUMP_D    = 3'd3,
    REG_TIME_STEP = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] potential_in;
    logic signed [DATA_W-1:0] recovery_in;
    logic signed [DATA_W-1:0] drive_current;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] potential_out;
    logic signed [DATA_W-1:0] recovery_out;
  } out_item_t;

  // step-length divider status
  typedef struct packed {
    logic            busy;
    logic [DT_W:0]   n;
    logic [DT_W-1:0] h;
  } div_stat_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic [SAT_W-DATA_W:0] top;
    top = x[SAT_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return x[DATA_W-1:0];
    end else if (x[SAT_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/izh_mul.sv -----
// Shared signed multiplier with registered product.
`default_nettype none
module izh_mul (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [izh_pkg::MUL_W-1:0]   a,
  input  wire logic signed [izh_pkg::MUL_W-1:0]   b,
  output logic signed      [izh_pkg::PROD_W-1:0]  p_r
);
  import izh_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule
`default_nettype wire

// ----- src/izh_div.sv -----
// Restoring divider that derives substep count n and substep length h from dt.
`default_nettype none
module izh_div #(
  parameter int FRAC_BITS = izh_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        reload,
  input  wire logic [izh_pkg::DT_W-1:0]    dt,
  output izh_pkg::div_stat_t               stat
);
  import izh_pkg::*;

  localparam int CNT_W = $clog2(DT_W + 1);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t          state_r;
  logic             stale_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DT_W:0]    den_r;
  logic [DT_W:0]    rem_r;
  logic [DT_W-1:0]  quo_r;
  logic [DT_W:0]    n_r;
  logic [DT_W-1:0]  h_r;

  logic [DT_W:0]    n_calc;
  logic [DT_W:0]    trial;
  logic             ge;

  assign n_calc = ({1'b0, dt} >> (FRAC_BITS - 1)) + (DT_W + 1)'(1);
  assign trial  = {rem_r[DT_W-1:0], quo_r[DT_W-1]};
  assign ge     = (trial >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      stale_r <= 1'b1;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        D_IDLE: begin
          stale_r <= reload;
          if (stale_r) begin
            den_r   <= n_calc;
            rem_r   <= '0;
            quo_r   <= dt;
            cnt_r   <= CNT_W'(DT_W);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          stale_r <= stale_r | reload;
          rem_r   <= ge ? (trial - den_r) : trial;
          quo_r   <= {quo_r[DT_W-2:0], ge};
          cnt_r   <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            h_r     <= {quo_r[DT_W-2:0], ge};
            n_r     <= den_r;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign stat.busy = stale_r || (state_r == D_RUN);
  assign stat.n    = n_r;
  assign stat.h    = h_r;

endmodule
`default_nettype wire

// ----- src/izhikevich_neuron_step_core.sv -----
// Izhikevich neuron step core: sequencer, datapath registers and configuration.
// Each item runs n substeps, n = floor(dt/0.5) + 1; a new item is accepted only when idle,
// after the previous result has been registered for output. Each substep makes seven
// passes through the single shared 33x33 multiplier plus post-processing in S_RV and S_UPD.
// After reset and after each time_step write, in_ready stays low while the step-length
// divider runs. Reset loads the default register values.
`default_nettype none
module izhikevich_neuron_step_core #(
  parameter int FRAC_BITS = izh_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire izh_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output izh_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [izh_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [izh_pkg::CFG_W-1:0]      cfg_wdata
);
  import izh_pkg::*;

  localparam int SQ_W   = 63 - FRAC_BITS;
  localparam int PL_W   = 28 + FRAC_BITS;
  localparam int BASE_W = 36;
  localparam longint K004 = ((longint'(4) <<< FRAC_BITS) + longint'(50)) / longint'(100);
  localparam longint K140 = longint'(140) <<< FRAC_BITS;
  localparam longint K30  = longint'(30) <<< FRAC_BITS;
  localparam logic signed [MUL_W-1:0]  K004_M = MUL_W'(K004);
  localparam logic signed [BASE_W-1:0] K140_B = BASE_W'(K140);
  localparam logic signed [DATA_W:0]   K30_S  = (DATA_W + 1)'(K30);

  typedef enum logic [3:0] {
    S_IDLE, S_VV, S_BV, S_QL, S_AI, S_QH, S_RU, S_RV, S_DV, S_UPD, S_DONE
  } state_t;

  state_t                    state_r;
  logic [DT_W:0]             cnt_r;
  logic signed [A_W-1:0]     a_r;
  logic signed [B_W-1:0]     b_r;
  logic signed [C_W-1:0]     c_r;
  logic signed [D_W-1:0]     d_r;
  logic [DT_W-1:0]           dt_r;

  logic signed [DATA_W-1:0]  v_r, u_r, cur_r;
  logic signed [BASE_W-1:0]  base_r;
  logic [SQ_W-1:0]           sq_r;
  logic signed [DATA_W-1:0]  inner_r, ru_r, unx_r, rv_r;
  logic [PL_W-1:0]           pl_r;
  logic [SQ_W-1:0]           quad_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  div_stat_t                 div_st;
  logic                      mul_en;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  p_r;

  logic signed [PROD_W-1:0]  p_sh;
  logic [63:0]               qsum;
  logic signed [BASE_W-1:0]  base_nxt;
  logic signed [DATA_W-1:0]  inner_nxt, ru_nxt, unx_nxt, rv_nxt, vn_nxt, ud_nxt;
  logic [SQ_W-1:0]           quad_nxt;
  logic                      spike;

  izh_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .reload (cfg_we && (cfg_idx == REG_TIME_STEP)),
    .dt     (dt_r),
    .stat   (div_st)
  );

  izh_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_VV: begin
        mul_a = MUL_W'(v_r);
        mul_b = MUL_W'(v_r);
      end
      S_BV: begin
        mul_a = MUL_W'(b_r);
        mul_b = MUL_W'(v_r);
      end
      S_QL: begin
        mul_a = MUL_W'({1'b0, sq_r[31:0]});
        mul_b = K004_M;
      end
      S_AI: begin
        mul_a = MUL_W'(a_r);
        mul_b = MUL_W'(inner_r);
      end
      S_QH: begin
        mul_a = MUL_W'({1'b0, sq_r[SQ_W-1:32]});
        mul_b = K004_M;
      end
      S_RU: begin
        mul_a = MUL_W'(ru_r);
        mul_b = MUL_W'(div_st.h);
      end
      S_DV: begin
        mul_a = MUL_W'(rv_r);
        mul_b = MUL_W'(div_st.h);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign p_sh     = p_r >>> FRAC_BITS;
  assign qsum     = {p_r[31:0], 32'd0} + 64'(pl_r);
  assign quad_nxt = qsum[SQ_W+FRAC_BITS-1:FRAC_BITS];
  assign base_nxt = (BASE_W'(v_r) <<< 2) + BASE_W'(v_r) + K140_B
                    - BASE_W'(u_r) + BASE_W'(cur_r);
  assign inner_nxt = sat32(SAT_W'(p_sh) - SAT_W'(u_r));
  assign ru_nxt    = sat32(SAT_W'(p_sh));
  assign unx_nxt   = sat32(SAT_W'(p_sh) + SAT_W'(u_r));
  assign rv_nxt    = sat32($signed(SAT_W'({1'b0, quad_r})) + SAT_W'(base_r));
  assign vn_nxt    = sat32(SAT_W'(p_sh) + SAT_W'(v_r));
  assign ud_nxt    = sat32(SAT_W'(unx_r) + SAT_W'(d_r));
  assign spike     = ($signed({vn_nxt[DATA_W-1], vn_nxt}) >= K30_S);

  assign in_ready  = (state_r == S_IDLE) && !div_st.busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      a_r         <= RESET_A;
      b_r         <= RESET_B;
      c_r         <= RESET_C;
      d_r         <= RESET_D;
      dt_r        <= RESET_DT;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_RATE_A:    a_r  <= cfg_wdata[A_W-1:0];
          REG_GAIN_B:    b_r  <= cfg_wdata[B_W-1:0];
          REG_RESET_C:   c_r  <= cfg_wdata[C_W-1:0];
          REG_JUMP_D:    d_r  <= cfg_wdata[D_W-1:0];
          REG_TIME_STEP: dt_r <= cfg_wdata[DT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            v_r     <= in_data.potential_in;
            u_r     <= in_data.recovery_in;
            cur_r   <= in_data.drive_current;
            cnt_r   <= div_st.n;
            state_r <= S_VV;
          end
        end
        S_VV: begin
          base_r  <= base_nxt;
          state_r <= S_BV;
        end
        S_BV: begin
          sq_r    <= p_r[SQ_W+FRAC_BITS-1:FRAC_BITS];
          state_r <= S_QL;
        end
        S_QL: begin
          inner_r <= inner_nxt;
          state_r <= S_AI;
        end
        S_AI: begin
          pl_r    <= p_r[PL_W-1:0];
          state_r <= S_QH;
        end
        S_QH: begin
          ru_r    <= ru_nxt;
          state_r <= S_RU;
        end
        S_RU: begin
          quad_r  <= quad_nxt;
          state_r <= S_RV;
        end
        S_RV: begin
          unx_r   <= unx_nxt;
          rv_r    <= rv_nxt;
          state_r <= S_DV;
        end
        S_DV: state_r <= S_UPD;
        S_UPD: begin
          if (spike) begin
            v_r <= DATA_W'(c_r);
            u_r <= ud_nxt;
          end else begin
            v_r <= vn_nxt;
            u_r <= unx_r;
          end
          cnt_r   <= cnt_r - (DT_W + 1)'(1);
          state_r <= (cnt_r == (DT_W + 1)'(1)) ? S_DONE : S_VV;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.potential_out <= v_r;
            out_data_r.recovery_out  <= u_r;
            out_valid_r              <= 1'b1;
            state_r                  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> !in_ready)
    else $error("input taken while step length is being recomputed");

  a_accept_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_VV) && (cnt_r == $past(div_st.n)))
    else $error("transaction did not start the substep sequence");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_DONE) |-> (cnt_r != '0))
    else $error("substep counter empty during computation");

  a_spike_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && spike) |=> (v_r == DATA_W'($past(c_r))))
    else $error("spike did not reset potential");

  a_done_publishes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_ready)) |=> out_valid_r && (state_r == S_IDLE))
    else $error("result not published");

endmodule
`default_nettype wire
